// ===== rtl/mpwa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mpwa_pkg
// Shared types, constants and helpers for the max pooling / argmax block.
// ----------------------------------------------------------------------------
package mpwa_pkg;

    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 64;
    localparam int MAX_PLANES  = 4;
    localparam int MAX_STRIDE  = 8;
    localparam int MAX_WINDOW  = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_PLANES;
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
    localparam int INDEX_BITS  = ADDR_BITS + 1;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 7;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PLANE_COUNT  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_STRIDE       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_SIZE  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_PADDING      = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_OUT_WIDTH    = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_OUT_HEIGHT   = 3'd7;

    // opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_POOL = 1'b1;

    // empty-window / error result
    localparam logic signed [SAMPLE_BITS-1:0] MOST_NEGATIVE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [INDEX_BITS-1:0]         NO_INDEX      = '1;

    typedef struct packed {
        logic [6:0] image_width;
        logic [6:0] image_height;
        logic [2:0] plane_count;
        logic [3:0] stride;
        logic [3:0] window_size;
        logic [2:0] padding;
        logic [6:0] out_width;
        logic [6:0] out_height;
    } cfg_t;

    typedef struct packed {
        logic [1:0] plane;
        logic [5:0] out_row;
        logic [5:0] out_col;
    } req_t;

    typedef struct packed {
        logic                          request_error;
        logic [ADDR_BITS-1:0]          out_index;
        logic [INDEX_BITS-1:0]         max_index;
        logic signed [SAMPLE_BITS-1:0] max_value;
    } res_t;

    // zero acts as one, oversize saturates at hi
    function automatic logic [6:0] sat_size(input logic [6:0] v, input logic [6:0] hi);
        logic [6:0] r;
        if (v == 7'd0)
            r = 7'd1;
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/max_pool_window_argmax.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// max_pool_window_argmax
// 2-D max pooling with padding and first-argmax over a stored feature map.
// ----------------------------------------------------------------------------
// A load word (tuser = 0) writes one Q8.8 sample into the 16384-entry feature
// store and produces no output word. A pool word (tuser = 1) returns one
// output word with the window maximum, its flat input index (-1 when the
// window lies wholly in padding) and the flat output index; tuser on the
// output is the request error flag. The store is a single-port RAM read one
// window position per cycle. After acceptance a pool word passes through the
// setup, scan, drain and result states, the last waiting until the output
// register is free; a bad request skips the scan and drain. Words are
// processed one at a time; a finished result waits in the output register
// while new words are accepted. Store entries hold no defined value until
// loaded.
// ----------------------------------------------------------------------------
module max_pool_window_argmax (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [6:0]  cfg_wdata,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // load_address, sample_value, plane, out_row, out_col
    input  wire logic        s_tuser,   // opcode
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // max_value, max_index, out_index
    output logic             m_tuser    // request_error
);
    import mpwa_pkg::*;

    cfg_t                   cfg;
    req_t                   req;
    res_t                   res;
    logic                   pool_idle;
    logic                   accept;
    logic                   load_we;
    logic                   pool_start;
    logic [ADDR_BITS-1:0]   rd_addr;
    logic [ADDR_BITS-1:0]   ram_addr;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic                   res_valid;
    logic                   res_ready;
    logic                   m_valid_reg;
    res_t                   out_reg;

    assign s_tready   = pool_idle;
    assign accept     = s_tvalid && s_tready;
    assign load_we    = accept && (s_tuser == OP_LOAD);
    assign pool_start = accept && (s_tuser == OP_POOL);

    assign req.plane   = s_tdata[31:30];
    assign req.out_row = s_tdata[37:32];
    assign req.out_col = s_tdata[43:38];

    assign ram_addr = load_we ? s_tdata[13:0] : rd_addr;

    mpwa_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mpwa_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (load_we),
        .addr  (ram_addr),
        .wdata (s_tdata[29:14]),
        .rdata (ram_rdata)
    );

    mpwa_pool u_pool (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .start     (pool_start),
        .req       (req),
        .idle      (pool_idle),
        .rd_addr   (rd_addr),
        .rd_data   (ram_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b0, out_reg.out_index, out_reg.max_index, out_reg.max_value};
    assign m_tuser  = out_reg.request_error;

endmodule
`default_nettype wire

// ===== rtl/mpwa_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mpwa_ram
// Generic single-port synchronous RAM, registered read, read-first.
// ----------------------------------------------------------------------------
module mpwa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

// ===== rtl/mpwa_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mpwa_cfg
// Configuration register file; values are held already saturated into range.
// ----------------------------------------------------------------------------
module mpwa_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [mpwa_pkg::CFG_IDX_BITS-1:0]  cfg_addr,
    input  wire logic [mpwa_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    output mpwa_pkg::cfg_t                         cfg
);
    import mpwa_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_IMAGE_WIDTH:
                    cfg_next.image_width  = sat_size(cfg_wdata, 7'(MAX_WIDTH));
                REG_IMAGE_HEIGHT:
                    cfg_next.image_height = sat_size(cfg_wdata, 7'(MAX_HEIGHT));
                REG_PLANE_COUNT:
                    cfg_next.plane_count  =
                        3'(sat_size({4'b0, cfg_wdata[2:0]}, 7'(MAX_PLANES)));
                REG_STRIDE:
                    cfg_next.stride       =
                        4'(sat_size({3'b0, cfg_wdata[3:0]}, 7'(MAX_STRIDE)));
                REG_WINDOW_SIZE:
                    cfg_next.window_size  =
                        4'(sat_size({3'b0, cfg_wdata[3:0]}, 7'(MAX_WINDOW)));
                REG_PADDING:
                    cfg_next.padding      = cfg_wdata[2:0];
                REG_OUT_WIDTH:
                    cfg_next.out_width    = sat_size(cfg_wdata, 7'(MAX_WIDTH));
                REG_OUT_HEIGHT:
                    cfg_next.out_height   = sat_size(cfg_wdata, 7'(MAX_HEIGHT));
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= 7'd64;
            cfg_reg.image_height <= 7'd64;
            cfg_reg.plane_count  <= 3'd4;
            cfg_reg.stride       <= 4'd2;
            cfg_reg.window_size  <= 4'd2;
            cfg_reg.padding      <= 3'd0;
            cfg_reg.out_width    <= 7'd32;
            cfg_reg.out_height   <= 7'd32;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== rtl/mpwa_pool.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mpwa_pool
// Window sequencer: address setup, one store read per window position,
// running max / first-argmax over the returned samples.
// ----------------------------------------------------------------------------
module mpwa_pool (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  mpwa_pkg::cfg_t                            cfg,
    input  wire logic                                 start,
    input  mpwa_pkg::req_t                            req,
    output logic                                      idle,
    output logic [mpwa_pkg::ADDR_BITS-1:0]            rd_addr,
    input  wire logic [mpwa_pkg::SAMPLE_BITS-1:0]     rd_data,
    output logic                                      res_valid,
    input  wire logic                                 res_ready,
    output mpwa_pkg::res_t                            res
);
    import mpwa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP_A,
        S_SETUP_B,
        S_SCAN,
        S_DRAIN,
        S_RESULT
    } state_t;

    state_t state_reg;
    logic   err_reg;
    logic   rd_pend_reg;
    logic   seen_reg;
    logic [2:0] fh_reg;
    logic [2:0] fw_reg;

    req_t                          req_reg;
    logic [8:0]                    t1_reg;
    logic [8:0]                    p1_reg;
    logic signed [11:0]            base_y_reg;
    logic signed [11:0]            base_x_reg;
    logic signed [11:0]            y_reg;
    logic signed [11:0]            x_reg;
    logic signed [19:0]            rowaddr_reg;
    logic [ADDR_BITS-1:0]          oidx_reg;
    logic [ADDR_BITS-1:0]          rd_idx_reg;
    logic signed [SAMPLE_BITS-1:0] best_reg;
    logic [INDEX_BITS-1:0]         best_idx_reg;

    logic                          req_bad;
    logic                          in_bounds;
    logic                          last_col;
    logic                          last_row;
    logic [9:0]                    row_st;
    logic [9:0]                    col_st;
    logic signed [11:0]            yp_sum;
    logic signed [19:0]            rowaddr_init;
    logic [15:0]                   oidx_full;
    logic signed [19:0]            addr_full;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          take;

    assign req_bad = ({1'b0, req.plane} >= cfg.plane_count)
                  || ({1'b0, req.out_row} >= cfg.out_height)
                  || ({1'b0, req.out_col} >= cfg.out_width);

    assign row_st = 10'(req_reg.out_row) * 10'(cfg.stride);
    assign col_st = 10'(req_reg.out_col) * 10'(cfg.stride);

    assign yp_sum       = base_y_reg + $signed({3'b0, p1_reg});
    assign rowaddr_init = $signed({13'b0, cfg.image_width}) * 20'(yp_sum);
    assign oidx_full    = 16'(req_reg.out_col)
                        + 16'(cfg.out_width) * (16'(req_reg.out_row) + 16'(t1_reg));

    assign in_bounds = !y_reg[11] && (y_reg[10:0] < {4'b0, cfg.image_height})
                    && !x_reg[11] && (x_reg[10:0] < {4'b0, cfg.image_width});
    assign addr_full = rowaddr_reg + 20'(x_reg);
    assign rd_addr   = addr_full[ADDR_BITS-1:0];

    assign last_col = ({1'b0, fw_reg} == (cfg.window_size - 4'd1));
    assign last_row = ({1'b0, fh_reg} == (cfg.window_size - 4'd1));

    assign sample = $signed(rd_data);
    assign take   = rd_pend_reg && (!seen_reg || (sample > best_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            err_reg     <= 1'b0;
            rd_pend_reg <= 1'b0;
            seen_reg    <= 1'b0;
            fh_reg      <= 3'd0;
            fw_reg      <= 3'd0;
        end
        else
        begin
            if (take)
            begin
                seen_reg <= 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    rd_pend_reg <= 1'b0;
                    if (start)
                    begin
                        err_reg  <= req_bad;
                        seen_reg <= 1'b0;
                        state_reg <= S_SETUP_A;
                    end
                end
                S_SETUP_A:
                begin
                    state_reg <= S_SETUP_B;
                end
                S_SETUP_B:
                begin
                    fh_reg    <= 3'd0;
                    fw_reg    <= 3'd0;
                    state_reg <= err_reg ? S_RESULT : S_SCAN;
                end
                S_SCAN:
                begin
                    rd_pend_reg <= in_bounds;
                    if (last_col)
                    begin
                        fw_reg <= 3'd0;
                        if (last_row)
                        begin
                            state_reg <= S_DRAIN;
                        end
                        else
                        begin
                            fh_reg <= fh_reg + 3'd1;
                        end
                    end
                    else
                    begin
                        fw_reg <= fw_reg + 3'd1;
                    end
                end
                S_DRAIN:
                begin
                    // last read's sample is compared this cycle
                    rd_pend_reg <= 1'b0;
                    state_reg   <= S_RESULT;
                end
                S_RESULT:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            req_reg      <= req;
            best_reg     <= MOST_NEGATIVE;
            best_idx_reg <= NO_INDEX;
        end
        if (state_reg == S_SETUP_A)
        begin
            t1_reg     <= 9'(cfg.out_height) * 9'(req_reg.plane);
            p1_reg     <= 9'(cfg.image_height) * 9'(req_reg.plane);
            base_y_reg <= 12'(row_st) - 12'(cfg.padding);
            base_x_reg <= 12'(col_st) - 12'(cfg.padding);
        end
        if (state_reg == S_SETUP_B)
        begin
            oidx_reg    <= oidx_full[ADDR_BITS-1:0];
            rowaddr_reg <= rowaddr_init;
            y_reg       <= base_y_reg;
            x_reg       <= base_x_reg;
        end
        if (state_reg == S_SCAN)
        begin
            rd_idx_reg <= rd_addr;
            if (last_col)
            begin
                x_reg       <= base_x_reg;
                y_reg       <= y_reg + 12'sd1;
                rowaddr_reg <= rowaddr_reg + $signed({13'b0, cfg.image_width});
            end
            else
            begin
                x_reg <= x_reg + 12'sd1;
            end
        end
        if (take)
        begin
            best_reg     <= sample;
            best_idx_reg <= {1'b0, rd_idx_reg};
        end
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESULT);

    always_comb
    begin
        if (err_reg)
        begin
            res.max_value     = MOST_NEGATIVE;
            res.max_index     = NO_INDEX;
            res.out_index     = '0;
            res.request_error = 1'b1;
        end
        else
        begin
            res.max_value     = best_reg;
            res.max_index     = best_idx_reg;
            res.out_index     = oidx_reg;
            res.request_error = 1'b0;
        end
    end

endmodule
`default_nettype wire

// ===== tb/sv/tb_max_pool_window_argmax.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_pool_window_argmax
// Self-checking bench for the max pooling / first-argmax block.
// ----------------------------------------------------------------------------
// Load words fill a local mirror of the feature store. Every pool word is
// predicted from that mirror and a shadow copy of the registers. The result
// is queued and compared field by field with each output word. Window
// positions are always loaded before a pool word can read them. Directed
// tests cover empty windows, ties, the most negative sample, bad requests and
// register saturation. Random phases then run under three idling mixes.
// ----------------------------------------------------------------------------
module tb_max_pool_window_argmax;
    import mpwa_pkg::*;

    localparam int LOAD_SETTLE = 8;     // a load may still be in flight
    localparam int END_SETTLE  = 100;   // longer than the slowest pool word
    localparam int TIMEOUT_NS  = 50_000_000;

    typedef struct {
        int iw, ih, pc, st, ws, pad, ow, oh;
    } geom_t;

    logic                      clk;
    logic                      rst_n     = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]   cfg_addr  = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [47:0]               s_tdata   = '0;
    logic                      s_tuser   = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [47:0]               m_tdata;
    logic                      m_tuser;

    // shadow registers (raw, masked to width) and store mirror
    logic [6:0]                cfg_reg [0:7];
    logic signed [15:0]        sample_mem [0:STORE_DEPTH-1];
    bit                        loaded [0:STORE_DEPTH-1];

    res_t                      pending_results [$];
    res_t                      oldest_result;
    int                        fail_count    = 0;
    int                        send_idle_pct = 0;
    int                        recv_idle_pct = 0;

    max_pool_window_argmax uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int clip(input int v, input int lo, input int hi);
        int r;
        r = v;
        if (r < lo)
            r = lo;
        if (r > hi)
            r = hi;
        return r;
    endfunction

    // registers as the block uses them
    function automatic geom_t geom_now();
        geom_t g;
        g.iw  = clip(cfg_reg[REG_IMAGE_WIDTH],  1, MAX_WIDTH);
        g.ih  = clip(cfg_reg[REG_IMAGE_HEIGHT], 1, MAX_HEIGHT);
        g.pc  = clip(cfg_reg[REG_PLANE_COUNT],  1, MAX_PLANES);
        g.st  = clip(cfg_reg[REG_STRIDE],       1, MAX_STRIDE);
        g.ws  = clip(cfg_reg[REG_WINDOW_SIZE],  1, MAX_WINDOW);
        g.pad = clip(cfg_reg[REG_PADDING],      0, 7);
        g.ow  = clip(cfg_reg[REG_OUT_WIDTH],    1, MAX_WIDTH);
        g.oh  = clip(cfg_reg[REG_OUT_HEIGHT],   1, MAX_HEIGHT);
        return g;
    endfunction

    function automatic res_t predict_pool(input int pl, input int row, input int col);
        geom_t              g;
        res_t               r;
        bit                 seen;
        int                 y, x, idx;
        logic signed [15:0] best;
        logic [14:0]        best_idx;
        g        = geom_now();
        seen     = 1'b0;
        best     = MOST_NEGATIVE;
        best_idx = NO_INDEX;
        r.request_error = 1'b0;
        r.out_index     = '0;
        if (pl >= g.pc || row >= g.oh || col >= g.ow)
        begin
            r.request_error = 1'b1;
        end
        else
        begin
            for (int fh = 0; fh < g.ws; fh++)
            begin
                for (int fw = 0; fw < g.ws; fw++)
                begin
                    y = row * g.st - g.pad + fh;
                    x = col * g.st - g.pad + fw;
                    if (y >= 0 && y < g.ih && x >= 0 && x < g.iw)
                    begin
                        idx = x + g.iw * (y + g.ih * pl);
                        // strict compare keeps the first maximum
                        if (!seen || sample_mem[idx] > best)
                        begin
                            best     = sample_mem[idx];
                            best_idx = 15'(idx);
                            seen     = 1'b1;
                        end
                    end
                end
            end
            r.out_index = 14'(col + g.ow * (row + g.oh * pl));
        end
        r.max_value = best;
        r.max_index = best_idx;
        return r;
    endfunction

    // bias toward extremes and a few small values so ties are common
    function automatic logic [15:0] pick_sample();
        logic [15:0] v;
        case ($urandom_range(0, 5))
            0:       v = MOST_NEGATIVE;
            1:       v = 16'h7FFF;
            2, 3:    v = 16'($urandom_range(0, 6)) - 16'd3;
            default: v = 16'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    // mostly legal, sometimes any 7-bit value
    function automatic logic [6:0] pick_reg(input int lo, input int hi);
        logic [6:0] v;
        if ($urandom_range(0, 7) == 0)
            v = 7'($urandom_range(0, 127));
        else
            v = 7'($urandom_range(lo, hi));
        return v;
    endfunction

    task automatic report_failure(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] %s", $realtime, what);
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
            report_failure($sformatf("%s mismatch: expected %h, got %h", field, want, got));
    endtask

    // output side: random stalls and the result check
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                report_failure($sformatf("output word %h with no pending result", m_tdata));
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                check_field("max_value", oldest_result.max_value, m_tdata[15:0]);
                check_field("max_index", 16'(oldest_result.max_index), 16'(m_tdata[30:16]));
                check_field("out_index", 16'(oldest_result.out_index), 16'(m_tdata[44:31]));
                check_field("request_error", 16'(oldest_result.request_error), 16'(m_tuser));
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_word(input logic op, input logic [47:0] data);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_load(input int addr, input logic [15:0] value);
        logic [47:0] data;
        data        = '0;
        data[13:0]  = 14'(addr);
        data[29:14] = value;
        data[43:30] = 14'($urandom_range(0, 16383));   // pool fields unused here
        send_word(OP_LOAD, data);
        sample_mem[addr] = value;
        loaded[addr]     = 1'b1;
    endtask

    // load every in-image window position not yet written
    task automatic fill_window(input int pl, input int row, input int col);
        geom_t g;
        int    y, x, idx;
        g = geom_now();
        if (pl < g.pc && row < g.oh && col < g.ow)
        begin
            for (int fh = 0; fh < g.ws; fh++)
            begin
                for (int fw = 0; fw < g.ws; fw++)
                begin
                    y = row * g.st - g.pad + fh;
                    x = col * g.st - g.pad + fw;
                    if (y >= 0 && y < g.ih && x >= 0 && x < g.iw)
                    begin
                        idx = x + g.iw * (y + g.ih * pl);
                        if (!loaded[idx])
                            send_load(idx, pick_sample());
                    end
                end
            end
        end
    endtask

    task automatic send_pool(input int pl, input int row, input int col);
        logic [47:0] data;
        fill_window(pl, row, col);
        data        = '0;
        data[29:0]  = 30'($urandom());                 // load fields unused here
        data[31:30] = 2'(pl);
        data[37:32] = 6'(row);
        data[43:38] = 6'(col);
        send_word(OP_POOL, data);
        pending_results.push_back(predict_pool(pl, row, col));
    endtask

    task automatic wait_idle(input int settle);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [6:0] value);
        logic [6:0] mask;
        case (idx)
            REG_PLANE_COUNT, REG_PADDING: mask = 7'h07;
            REG_STRIDE, REG_WINDOW_SIZE:  mask = 7'h0F;
            default:                      mask = 7'h7F;
        endcase
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_reg[idx] = value & mask;
    endtask

    task automatic apply_config(input logic [6:0] iw, input logic [6:0] ih,
                                input logic [6:0] pc, input logic [6:0] st,
                                input logic [6:0] ws, input logic [6:0] pad,
                                input logic [6:0] ow, input logic [6:0] oh);
        wait_idle(LOAD_SETTLE);
        write_reg(REG_IMAGE_WIDTH,  iw);
        write_reg(REG_IMAGE_HEIGHT, ih);
        write_reg(REG_PLANE_COUNT,  pc);
        write_reg(REG_STRIDE,       st);
        write_reg(REG_WINDOW_SIZE,  ws);
        write_reg(REG_PADDING,      pad);
        write_reg(REG_OUT_WIDTH,    ow);
        write_reg(REG_OUT_HEIGHT,   oh);
        cfg_we <= 1'b0;
    endtask

    task automatic test_empty_window();
        // stride 8, pad 7: some windows fall wholly into padding
        apply_config(7'd2, 7'd2, 7'd1, 7'd8, 7'd2, 7'd7, 7'd2, 7'd2);
        send_pool(0, 0, 0);
        send_pool(0, 1, 1);
        send_pool(0, 0, 1);
    endtask

    task automatic test_ties_and_extremes();
        apply_config(7'd3, 7'd1, 7'd1, 7'd1, 7'd3, 7'd0, 7'd1, 7'd1);
        // all most-negative: still a real sample, first index wins
        send_load(0, MOST_NEGATIVE);
        send_load(1, MOST_NEGATIVE);
        send_load(2, MOST_NEGATIVE);
        send_pool(0, 0, 0);
        send_load(1, 16'sd7);
        send_load(2, 16'sd7);
        send_pool(0, 0, 0);
        send_load(2, 16'sh7FFF);
        send_pool(0, 0, 0);
    endtask

    task automatic test_bad_request();
        apply_config(7'd4, 7'd4, 7'd2, 7'd1, 7'd2, 7'd0, 7'd3, 7'd3);
        send_pool(2, 0, 0);
        send_pool(0, 3, 0);
        send_pool(0, 0, 3);
        send_pool(3, 63, 63);
    endtask

    task automatic test_register_saturation();
        // zeros act as one
        apply_config(7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0);
        send_pool(0, 0, 0);
        send_pool(1, 0, 0);
        // oversize values clamp to the maximum, narrow registers drop high bits
        apply_config(7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127);
        send_pool(3, 63, 63);
        send_pool(0, 0, 0);
    endtask

    task automatic run_random_phase(input int n_items);
        geom_t g;
        int    r;
        g = geom_now();
        for (int i = 0; i < n_items; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
                send_load($urandom_range(0, STORE_DEPTH - 1), 16'($urandom_range(0, 65535)));
            else if (r < 30)
                send_load($urandom_range(0, g.iw - 1)
                          + g.iw * ($urandom_range(0, g.ih - 1)
                          + g.ih * $urandom_range(0, g.pc - 1)), pick_sample());
            else if (r < 40)
                send_pool($urandom_range(0, 3), $urandom_range(0, 63), $urandom_range(0, 63));
            else
                send_pool($urandom_range(0, g.pc - 1), $urandom_range(0, g.oh - 1),
                          $urandom_range(0, g.ow - 1));
        end
    endtask

    task automatic test_random_pooling();
        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 29 : (mode == 1) ? 82 : 0;
            recv_idle_pct = (mode == 0) ? 82 : (mode == 1) ? 29 : 0;
            for (int c = 0; c < 4; c++)
            begin
                apply_config(pick_reg(1, 16), pick_reg(1, 16), pick_reg(1, 4),
                             pick_reg(1, 8), pick_reg(1, 8), pick_reg(0, 7),
                             pick_reg(1, 12), pick_reg(1, 12));
                run_random_phase(50);
            end
        end
    endtask

    task automatic test_largest_sizes();
        // full 8x8 windows on a full-size store
        apply_config(7'd64, 7'd64, 7'd4, 7'd1, 7'd8, 7'd0, 7'd57, 7'd57);
        send_pool(3, 56, 56);
        send_pool(0, 0, 0);
        apply_config(7'd64, 7'd64, 7'd4, 7'd8, 7'd8, 7'd7, 7'd64, 7'd64);
        send_pool(2, 1, 1);
        send_pool(3, 63, 63);
    endtask

    initial
    begin
        cfg_reg[REG_IMAGE_WIDTH]  = 7'd64;
        cfg_reg[REG_IMAGE_HEIGHT] = 7'd64;
        cfg_reg[REG_PLANE_COUNT]  = 7'd4;
        cfg_reg[REG_STRIDE]       = 7'd2;
        cfg_reg[REG_WINDOW_SIZE]  = 7'd2;
        cfg_reg[REG_PADDING]      = 7'd0;
        cfg_reg[REG_OUT_WIDTH]    = 7'd32;
        cfg_reg[REG_OUT_HEIGHT]   = 7'd32;
        send_idle_pct = 29;
        recv_idle_pct = 82;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_window();
        test_ties_and_extremes();
        test_bad_request();
        test_register_saturation();
        test_random_pooling();
        test_largest_sizes();

        wait_idle(END_SETTLE);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
